/* hw/rtl/istk_pkg.sv */
// shared constants and codes of the indexed stack
`default_nettype none
package istk_pkg;

   localparam int OPCODE_BITS = 3;
   localparam int INDEX_BITS  = 8;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_BITS  = 9;

   localparam int DEFAULT_DEPTH     = 256;
   localparam int DEFAULT_ELEM_BITS = 32;

   localparam logic [OPCODE_BITS-1:0] OP_READ  = 3'd0;
   localparam logic [OPCODE_BITS-1:0] OP_WRITE = 3'd1;
   localparam logic [OPCODE_BITS-1:0] OP_PUSH  = 3'd2;
   localparam logic [OPCODE_BITS-1:0] OP_POP   = 3'd3;
   localparam logic [OPCODE_BITS-1:0] OP_PEEK  = 3'd4;

   localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd3;

endpackage
`default_nettype wire

/* hw/rtl/istk_ram.sv */
// generic single write port ram with registered read
`default_nettype none
module istk_ram #(
   parameter int WIDTH = istk_pkg::DEFAULT_ELEM_BITS,
   parameter int DEPTH = istk_pkg::DEFAULT_DEPTH,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hw/rtl/indexed_stack_with_used_bits.sv */
// indexed stack top level: stack pointer, written bits, element ram and result register
//
//   channel   ports                                                  handshake
//   request   req_opcode, req_index, req_write_data                  start && !busy
//   response  rsp_read_data, rsp_was_written, rsp_status, rsp_count  rsp_valid, one cycle
//
// one transaction per cycle; its response appears the cycle after it is accepted.
// the figure comes from one ram access per transaction, read and written at the accept edge,
// with the top pointer and written bits kept in flip-flops.
// reset clears the top pointer and all written bits; an entry whose written bit is clear
// reads as all-ones poison, so the ram needs no clearing pass.
// busy is held low: the block never stalls and the receiver cannot stall.
`default_nettype none
module indexed_stack_with_used_bits #(
   parameter int DEPTH     = istk_pkg::DEFAULT_DEPTH,
   parameter int ELEM_BITS = istk_pkg::DEFAULT_ELEM_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [istk_pkg::OPCODE_BITS-1:0]   req_opcode,
   input  wire logic [istk_pkg::INDEX_BITS-1:0]    req_index,
   input  wire logic [ELEM_BITS-1:0]               req_write_data,
   output logic                                    rsp_valid,
   output logic      [ELEM_BITS-1:0]               rsp_read_data,
   output logic                                    rsp_was_written,
   output logic      [istk_pkg::STATUS_BITS-1:0]   rsp_status,
   output logic      [istk_pkg::COUNT_BITS-1:0]    rsp_count
);

   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PTR_BITS  = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_FULL = PTR_BITS'(DEPTH);

   logic                 accept;
   logic [PTR_BITS-1:0]  top_ff, top_in;
   logic [DEPTH-1:0]     written_ff, written_in;
   logic [ADDR_BITS-1:0] idx_addr, top_addr, pop_addr;
   logic                 idx_ok;

   logic                 ram_we, ram_re;
   logic [ADDR_BITS-1:0] ram_waddr, ram_raddr;
   logic [ELEM_BITS-1:0] ram_q;

   logic                            valid_ff, valid_in;
   logic [ELEM_BITS-1:0]            data_ff, data_in;
   logic                            wbit_ff, wbit_in;
   logic [istk_pkg::STATUS_BITS-1:0] status_ff, status_in;
   logic                            mem_sel_ff, mem_sel_in;
   logic                            poison_sel_ff, poison_sel_in;

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign idx_addr = ADDR_BITS'(req_index);
   assign idx_ok   = int'(req_index) < DEPTH;
   assign top_addr = ADDR_BITS'(top_ff);
   assign pop_addr = ADDR_BITS'(top_ff - 1'b1);

   always_comb begin
      top_in        = top_ff;
      written_in    = written_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_waddr     = idx_addr;
      ram_raddr     = idx_addr;
      valid_in      = accept;
      data_in       = '0;
      wbit_in       = 1'b0;
      status_in     = istk_pkg::ST_OK;
      mem_sel_in    = 1'b0;
      poison_sel_in = 1'b0;
      if (accept) begin
         case (req_opcode)
            istk_pkg::OP_READ: begin
               if (!idx_ok) begin
                  status_in = istk_pkg::ST_RANGE;
               end else begin
                  ram_re        = written_ff[idx_addr];
                  wbit_in       = written_ff[idx_addr];
                  mem_sel_in    = written_ff[idx_addr];
                  poison_sel_in = !written_ff[idx_addr];
               end
            end
            istk_pkg::OP_WRITE: begin
               if (!idx_ok) begin
                  status_in = istk_pkg::ST_RANGE;
               end else begin
                  ram_we               = 1'b1;
                  written_in[idx_addr] = 1'b1;
                  data_in              = req_write_data;
                  wbit_in              = 1'b1;
               end
            end
            istk_pkg::OP_PUSH: begin
               if (top_ff == PTR_FULL) begin
                  status_in = istk_pkg::ST_FULL;
               end else begin
                  ram_we               = 1'b1;
                  ram_waddr            = top_addr;
                  written_in[top_addr] = 1'b1;
                  top_in               = top_ff + 1'b1;
                  data_in              = req_write_data;
                  wbit_in              = 1'b1;
               end
            end
            istk_pkg::OP_POP, istk_pkg::OP_PEEK: begin
               if (top_ff == '0) begin
                  status_in = istk_pkg::ST_EMPTY;
               end else begin
                  ram_raddr     = pop_addr;
                  ram_re        = written_ff[pop_addr];
                  wbit_in       = written_ff[pop_addr];
                  mem_sel_in    = written_ff[pop_addr];
                  poison_sel_in = !written_ff[pop_addr];
                  // pop leaves poison behind: a clear written bit reads as poison
                  if (req_opcode == istk_pkg::OP_POP) begin
                     written_in[pop_addr] = 1'b0;
                     top_in               = top_ff - 1'b1;
                  end
               end
            end
            default: begin
               status_in = istk_pkg::ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff     <= '0;
         written_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         top_ff     <= top_in;
         written_ff <= written_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff       <= data_in;
      wbit_ff       <= wbit_in;
      status_ff     <= status_in;
      mem_sel_ff    <= mem_sel_in;
      poison_sel_ff <= poison_sel_in;
   end

   istk_ram #(
      .WIDTH (ELEM_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_write_data),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   always_comb begin
      if (mem_sel_ff) begin
         rsp_read_data = ram_q;
      end else if (poison_sel_ff) begin
         rsp_read_data = '1;
      end else begin
         rsp_read_data = data_ff;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_was_written = wbit_ff;
   assign rsp_status      = status_ff;
   // top pointer already holds the value after the transaction
   assign rsp_count       = istk_pkg::COUNT_BITS'(top_ff);

endmodule
`default_nettype wire
